/* sv/spq_pkg.sv */
// Package: sizes, codes and shared types for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH         = 16;
    localparam int TAG_BITS      = 16;
    localparam int PRIORITY_BITS = 32;
    localparam int ADDR_BITS     = $clog2(DEPTH);
    localparam int CNT_BITS      = $clog2(DEPTH + 1);
    localparam int ENTRY_BITS    = TAG_BITS + PRIORITY_BITS;

    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_PUT,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [TAG_BITS-1:0]             tag;
        logic signed [PRIORITY_BITS-1:0] prio;
        logic [CNT_BITS-1:0]             entries;
        t_status                         status;
    } t_res;

    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  waddr;
        logic [ENTRY_BITS-1:0] wdata;
        logic [ADDR_BITS-1:0]  raddr;
    } t_mem_req;

    function automatic logic [ADDR_BITS-1:0] phys_addr(
        input logic [ADDR_BITS-1:0] base,
        input logic [ADDR_BITS-1:0] offs
    );
        logic [ADDR_BITS:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= (ADDR_BITS + 1)'(DEPTH)) begin
            sum = sum - (ADDR_BITS + 1)'(DEPTH);
        end
        return sum[ADDR_BITS-1:0];
    endfunction

endpackage

/* sv/spq_ram.sv */
// Entry store: one write port, one read port with registered read data.
module spq_ram (
    input  logic                          i_clk,
    input  spq_pkg::t_mem_req             i_req,
    output logic [spq_pkg::ENTRY_BITS-1:0] o_rdata
);

    logic [spq_pkg::ENTRY_BITS-1:0] r_mem [spq_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule

/* sv/spq_ctrl.sv */
// Sequencer: ring-buffer head, count, insertion scan and result capture.
module spq_ctrl (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [1:0]                           i_opcode,
    input  logic [spq_pkg::TAG_BITS-1:0]         i_value_tag,
    input  logic signed [spq_pkg::PRIORITY_BITS-1:0] i_priority_req,
    output spq_pkg::t_mem_req                    o_mem,
    input  logic [spq_pkg::ENTRY_BITS-1:0]       i_rdata,
    output logic                                 o_res_valid,
    output spq_pkg::t_res                        o_res,
    input  logic                                 i_res_ready
);

    spq_pkg::t_state                          r_state, n_state;
    logic [spq_pkg::ADDR_BITS-1:0]            r_head, n_head;
    logic [spq_pkg::CNT_BITS-1:0]             r_count, n_count;
    logic [spq_pkg::ADDR_BITS-1:0]            r_j, n_j;
    spq_pkg::t_op                             r_op, n_op;
    logic [spq_pkg::TAG_BITS-1:0]             r_tag, n_tag;
    logic signed [spq_pkg::PRIORITY_BITS-1:0] r_prio, n_prio;
    spq_pkg::t_res                            r_res, n_res;

    logic                                     fin;
    spq_pkg::t_res                            fin_res;
    spq_pkg::t_op                             op_in;
    logic [spq_pkg::CNT_BITS-1:0]             cnt_m1;
    logic [spq_pkg::CNT_BITS-1:0]             cnt_p1;
    logic [spq_pkg::TAG_BITS-1:0]             rd_tag;
    logic signed [spq_pkg::PRIORITY_BITS-1:0] rd_prio;
    logic                                     shift;

    assign op_in   = spq_pkg::t_op'(i_opcode);
    assign cnt_m1  = r_count - spq_pkg::CNT_BITS'(1);
    assign cnt_p1  = r_count + spq_pkg::CNT_BITS'(1);
    assign rd_tag  = i_rdata[spq_pkg::ENTRY_BITS-1:spq_pkg::PRIORITY_BITS];
    assign rd_prio = signed'(i_rdata[spq_pkg::PRIORITY_BITS-1:0]);
    assign shift   = (r_j == '0) ? (rd_prio > r_prio) : (rd_prio >= r_prio);
    assign o_stall = (r_state != spq_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_head  = r_head;
        n_count = r_count;
        n_j     = r_j;
        n_op    = r_op;
        n_tag   = r_tag;
        n_prio  = r_prio;
        n_res   = r_res;
        fin     = 1'b0;
        fin_res = '{tag: '0, prio: '0, entries: r_count, status: spq_pkg::STS_OK};
        o_mem   = '{we: 1'b0, waddr: '0, wdata: '0,
                    raddr: spq_pkg::phys_addr(r_head, '0)};

        case (r_state)
            spq_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_op   = op_in;
                    n_tag  = i_value_tag;
                    n_prio = i_priority_req;
                    case (op_in)
                        spq_pkg::OP_ENQ: begin
                            if (r_count == spq_pkg::CNT_BITS'(spq_pkg::DEPTH)) begin
                                fin            = 1'b1;
                                fin_res.status = spq_pkg::STS_FULL;
                            end else if (r_count == '0) begin
                                o_mem.we        = 1'b1;
                                o_mem.waddr     = spq_pkg::phys_addr(r_head, '0);
                                o_mem.wdata     = {i_value_tag, i_priority_req};
                                n_count         = cnt_p1;
                                fin             = 1'b1;
                                fin_res.entries = cnt_p1;
                            end else begin
                                o_mem.raddr = spq_pkg::phys_addr(r_head,
                                                  cnt_m1[spq_pkg::ADDR_BITS-1:0]);
                                n_j         = cnt_m1[spq_pkg::ADDR_BITS-1:0];
                                n_state     = spq_pkg::ST_SCAN;
                            end
                        end
                        spq_pkg::OP_CLEAR: begin
                            n_count         = '0;
                            n_head          = '0;
                            fin             = 1'b1;
                            fin_res.entries = '0;
                        end
                        default: begin
                            if (r_count == '0) begin
                                fin            = 1'b1;
                                fin_res.status = spq_pkg::STS_EMPTY;
                            end else begin
                                n_state = spq_pkg::ST_READ;
                            end
                        end
                    endcase
                end
            end
            spq_pkg::ST_READ: begin
                fin          = 1'b1;
                fin_res.tag  = rd_tag;
                fin_res.prio = rd_prio;
                if (r_op == spq_pkg::OP_DEQ) begin
                    n_head          = spq_pkg::phys_addr(r_head,
                                          spq_pkg::ADDR_BITS'(1));
                    n_count         = cnt_m1;
                    fin_res.entries = cnt_m1;
                end
            end
            spq_pkg::ST_SCAN: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = spq_pkg::phys_addr(r_head,
                                  r_j + spq_pkg::ADDR_BITS'(1));
                if (shift) begin
                    o_mem.wdata = i_rdata;
                    if (r_j == '0) begin
                        n_state = spq_pkg::ST_PUT;
                    end else begin
                        o_mem.raddr = spq_pkg::phys_addr(r_head,
                                          r_j - spq_pkg::ADDR_BITS'(1));
                        n_j         = r_j - spq_pkg::ADDR_BITS'(1);
                    end
                end else begin
                    o_mem.wdata     = {r_tag, r_prio};
                    n_count         = cnt_p1;
                    fin             = 1'b1;
                    fin_res.entries = cnt_p1;
                end
            end
            spq_pkg::ST_PUT: begin
                o_mem.we        = 1'b1;
                o_mem.waddr     = spq_pkg::phys_addr(r_head, '0);
                o_mem.wdata     = {r_tag, r_prio};
                n_count         = cnt_p1;
                fin             = 1'b1;
                fin_res.entries = cnt_p1;
            end
            spq_pkg::ST_HOLD: begin
                if (i_res_ready) begin
                    n_state = spq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spq_pkg::ST_IDLE;
            end
        endcase

        // park the result when the output register is still occupied
        if (fin) begin
            if (i_res_ready) begin
                n_state = spq_pkg::ST_IDLE;
            end else begin
                n_res   = fin_res;
                n_state = spq_pkg::ST_HOLD;
            end
        end

        o_res_valid = fin || (r_state == spq_pkg::ST_HOLD);
        o_res       = (r_state == spq_pkg::ST_HOLD) ? r_res : fin_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::ST_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_op   <= n_op;
        r_tag  <= n_tag;
        r_prio <= n_prio;
        r_res  <= n_res;
    end

endmodule

/* sv/sorted_priority_queue.sv */
// Top level: sorted priority queue with ring-buffer entry store and output register.
//
//  channel   direction   valid     stall     payload
//  request   in          i_valid   o_stall   i_opcode, i_value_tag, i_priority_req
//  result    out         o_valid   i_stall   o_out_tag, o_out_priority, o_entries, o_status
//
// Clear, an enqueue into an empty queue, and full or empty results finish in the idle state.
// Dequeue and peek pass through a read state that waits for the registered read data of the entry store.
// Enqueue into a non-empty queue runs an insertion scan that walks the store from the
// tail, moving one entry a cycle (at most DEPTH - 1 entries moved), and then writes
// the new entry into the slot that the scan opened.
// Reset clears the sequencer state, count, head and output valid only; the store needs no clearing pass.
// A result waits in the output register while i_stall is high; the next request is
// taken meanwhile and its result is held inside until the register frees.
module sorted_priority_queue (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_stall,
    input  logic [1:0]                               i_opcode,
    input  logic [spq_pkg::TAG_BITS-1:0]             i_value_tag,
    input  logic signed [spq_pkg::PRIORITY_BITS-1:0] i_priority_req,
    output logic                                     o_valid,
    input  logic                                     i_stall,
    output logic [spq_pkg::TAG_BITS-1:0]             o_out_tag,
    output logic signed [spq_pkg::PRIORITY_BITS-1:0] o_out_priority,
    output logic [spq_pkg::CNT_BITS-1:0]             o_entries,
    output logic [1:0]                               o_status
);

    spq_pkg::t_mem_req              mem_req;
    logic [spq_pkg::ENTRY_BITS-1:0] mem_rdata;
    logic                           res_valid;
    spq_pkg::t_res                  res;
    logic                           res_ready;
    logic                           r_out_valid;
    spq_pkg::t_res                  r_out;

    assign res_ready = !r_out_valid || !i_stall;

    spq_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_value_tag    (i_value_tag),
        .i_priority_req (i_priority_req),
        .o_mem          (mem_req),
        .i_rdata        (mem_rdata),
        .o_res_valid    (res_valid),
        .o_res          (res),
        .i_res_ready    (res_ready)
    );

    spq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_tag      = r_out.tag;
    assign o_out_priority = r_out.prio;
    assign o_entries      = r_out.entries;
    assign o_status       = r_out.status;

`ifndef SYNTHESIS
    a_entries_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.entries <= spq_pkg::CNT_BITS'(spq_pkg::DEPTH)))
        else $error("entry count above depth");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_valid && !res_ready) |=> res_valid)
        else $error("result dropped while output register busy");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == spq_pkg::STS_EMPTY) |-> (r_out.entries == '0))
        else $error("empty status with nonzero count");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == spq_pkg::STS_FULL)
            |-> (r_out.entries == spq_pkg::CNT_BITS'(spq_pkg::DEPTH)))
        else $error("full status below depth");
`endif

endmodule

/* tb/sorted_priority_queue_test.sv */
// Self-checking testbench for the sorted priority queue: directed and random requests against a predictor.
module sorted_priority_queue_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT       = 400000;
    localparam int NUM_REQS    = 450;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = spq_pkg::DEPTH + 24;

    typedef struct {
        spq_pkg::t_op                             op;
        logic [spq_pkg::TAG_BITS-1:0]             tag;
        logic signed [spq_pkg::PRIORITY_BITS-1:0] prio;
        bit                                       hold_back;
    } t_req;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     i_valid = 1'b0;
    logic                                     o_stall;
    logic [1:0]                               i_opcode = '0;
    logic [spq_pkg::TAG_BITS-1:0]             i_value_tag = '0;
    logic signed [spq_pkg::PRIORITY_BITS-1:0] i_priority_req = '0;
    logic                                     o_valid;
    logic                                     i_stall = 1'b0;
    logic [spq_pkg::TAG_BITS-1:0]             o_out_tag;
    logic signed [spq_pkg::PRIORITY_BITS-1:0] o_out_priority;
    logic [spq_pkg::CNT_BITS-1:0]             o_entries;
    logic [1:0]                               o_status;

    t_req          pending_reqs[$];
    spq_pkg::t_res result_fifo[$];

    logic [spq_pkg::TAG_BITS-1:0]             slot_tag [spq_pkg::DEPTH];
    logic signed [spq_pkg::PRIORITY_BITS-1:0] slot_prio [spq_pkg::DEPTH];
    int                                       slot_count = 0;
    int                                       gen_count = 0;

    int sent_cnt = 0;
    int got_cnt = 0;
    int fail_cnt = 0;
    int cycle_cnt = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sorted_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_value_tag    (i_value_tag),
        .i_priority_req (i_priority_req),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_tag      (o_out_tag),
        .o_out_priority (o_out_priority),
        .o_entries      (o_entries),
        .o_status       (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic int sender_idle_pct(int n);
        if (n < 150) return 25;
        if (n < 300) return 81;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int n);
        if (n < 150) return 81;
        if (n < 300) return 25;
        return 0;
    endfunction

    function automatic spq_pkg::t_res queue_result(spq_pkg::t_op op,
                                                   logic [spq_pkg::TAG_BITS-1:0] tag,
                                                   logic signed [spq_pkg::PRIORITY_BITS-1:0] prio);
        spq_pkg::t_res r;
        int            pos;
        int            i;
        r = '0;
        r.status = spq_pkg::STS_OK;
        case (op)
            spq_pkg::OP_ENQ: begin
                if (slot_count >= spq_pkg::DEPTH) begin
                    r.status = spq_pkg::STS_FULL;
                end else begin
                    if (slot_count == 0 || prio < slot_prio[0]) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < slot_count && slot_prio[pos] < prio) pos++;
                    end
                    for (i = slot_count; i > pos; i--) begin
                        slot_tag[i]  = slot_tag[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_tag[pos]  = tag;
                    slot_prio[pos] = prio;
                    slot_count++;
                end
            end
            spq_pkg::OP_CLEAR: begin
                slot_count = 0;
            end
            default: begin
                if (slot_count == 0) begin
                    r.status = spq_pkg::STS_EMPTY;
                end else begin
                    r.tag  = slot_tag[0];
                    r.prio = slot_prio[0];
                    if (op == spq_pkg::OP_DEQ) begin
                        for (i = 1; i < slot_count; i++) begin
                            slot_tag[i-1]  = slot_tag[i];
                            slot_prio[i-1] = slot_prio[i];
                        end
                        slot_count--;
                    end
                end
            end
        endcase
        r.entries = spq_pkg::CNT_BITS'(slot_count);
        return r;
    endfunction

    task automatic add_req(spq_pkg::t_op op, logic [31:0] tag,
                           logic signed [spq_pkg::PRIORITY_BITS-1:0] prio);
        t_req r;
        r.op = op;
        r.tag = tag[spq_pkg::TAG_BITS-1:0];
        r.prio = prio;
        r.hold_back = (pending_reqs.size() == 16 || pending_reqs.size() == 300);
        pending_reqs.push_back(r);
        case (op)
            spq_pkg::OP_ENQ:   if (gen_count < spq_pkg::DEPTH) gen_count++;
            spq_pkg::OP_DEQ:   if (gen_count > 0) gen_count--;
            spq_pkg::OP_CLEAR: gen_count = 0;
            default:  ;
        endcase
    endtask

    function automatic logic signed [spq_pkg::PRIORITY_BITS-1:0] pick_priority(int mode);
        case (mode)
            0: return $urandom;
            1: begin
                case ($urandom_range(6))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    default: return ($signed($urandom_range(4)) - 2) <<< 16;
                endcase
            end
            default: return $urandom_range(7) << 16;
        endcase
    endfunction

    function automatic spq_pkg::t_op pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 40) return spq_pkg::OP_ENQ;
        if (r < 70) return spq_pkg::OP_DEQ;
        if (r < 95) return spq_pkg::OP_PEEK;
        return spq_pkg::OP_CLEAR;
    endfunction

    initial begin
        int kind;
        int mode;
        int n;
        int k;
        add_req(spq_pkg::OP_DEQ,   $urandom, $urandom);
        add_req(spq_pkg::OP_PEEK,  $urandom, $urandom);
        add_req(spq_pkg::OP_ENQ,   32'h0000_FFFF, 32'sh7FFF_FFFF);
        add_req(spq_pkg::OP_ENQ,   32'h0000_0000, 32'sh8000_0000);
        add_req(spq_pkg::OP_ENQ,   32'h0000_1111, 32'sh8000_0000);
        add_req(spq_pkg::OP_ENQ,   32'h0000_2222, 32'sh7FFF_FFFF);
        add_req(spq_pkg::OP_ENQ,   32'h0000_3333, 32'sh0001_0000);
        add_req(spq_pkg::OP_ENQ,   32'h0000_4444, 32'sh0001_0000);
        add_req(spq_pkg::OP_PEEK,  $urandom, $urandom);
        add_req(spq_pkg::OP_DEQ,   $urandom, $urandom);
        add_req(spq_pkg::OP_DEQ,   $urandom, $urandom);
        add_req(spq_pkg::OP_DEQ,   $urandom, $urandom);
        add_req(spq_pkg::OP_CLEAR, $urandom, $urandom);
        add_req(spq_pkg::OP_PEEK,  $urandom, $urandom);
        add_req(spq_pkg::OP_DEQ,   $urandom, $urandom);
        add_req(spq_pkg::OP_CLEAR, $urandom, $urandom);

        while (pending_reqs.size() < NUM_REQS) begin
            kind = $urandom_range(7);
            mode = $urandom_range(2);
            case (kind)
                4, 5: begin
                    n = spq_pkg::DEPTH - gen_count + $urandom_range(2);
                    for (k = 0; k < n; k++) begin
                        add_req(spq_pkg::OP_ENQ, $urandom, pick_priority(mode));
                    end
                end
                6: begin
                    n = gen_count + $urandom_range(2);
                    for (k = 0; k < n; k++) begin
                        add_req(($urandom_range(3) == 0) ? spq_pkg::OP_PEEK : spq_pkg::OP_DEQ,
                                $urandom, $urandom);
                    end
                end
                7: add_req(spq_pkg::OP_CLEAR, $urandom, $urandom);
                default: begin
                    n = $urandom_range(5, 30);
                    for (k = 0; k < n; k++) begin
                        add_req(pick_op(), $urandom, pick_priority(mode));
                    end
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || got_cnt != sent_cnt) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (result_fifo.size() != 0) fail_cnt += result_fifo.size();
        if (fail_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    always @(posedge i_clk) begin : drive
        t_req nxt;
        int   acc;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            acc = sent_cnt;
            if (i_valid && !o_stall) begin
                result_fifo.push_back(queue_result(spq_pkg::t_op'(i_opcode), i_value_tag,
                                                   i_priority_req));
                acc = acc + 1;
            end
            sent_cnt <= acc;
            if (!(i_valid && o_stall)) begin
                if (pending_reqs.size() != 0 && (!pending_reqs[0].hold_back || got_cnt == acc)
                    && $urandom_range(99) >= sender_idle_pct(acc)) begin
                    nxt = pending_reqs.pop_front();
                    i_valid        <= 1'b1;
                    i_opcode       <= nxt.op;
                    i_value_tag    <= nxt.tag;
                    i_priority_req <= nxt.prio;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            hold_left <= 0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && got_cnt >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < receiver_idle_pct(sent_cnt));
        end
    end

    always @(posedge i_clk) begin : check
        spq_pkg::t_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            got_cnt <= got_cnt + 1;
            if (result_fifo.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("unexpected result: tag %h prio %h entries %0d status %0d",
                             o_out_tag, o_out_priority, o_entries, o_status);
                end
            end else begin
                want = result_fifo.pop_front();
                if (o_out_tag !== want.tag || o_out_priority !== want.prio
                    || o_entries !== want.entries || o_status !== want.status) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("mismatch on result %0d: tag %h/%h prio %h/%h",
                                 got_cnt, want.tag, o_out_tag, want.prio, o_out_priority,
                                 " entries %0d/%0d status %0d/%0d (expected/actual)",
                                 want.entries, o_entries, want.status, o_status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

/* files.f */
sv/spq_pkg.sv
sv/spq_ram.sv
sv/spq_ctrl.sv
sv/sorted_priority_queue.sv
tb/sorted_priority_queue_test.sv
